// File: rtl/snf_pkg.sv
package snf_pkg;

  // FIFO geometry; pointers count modulo twice the depth
  localparam int RX_DEPTH = 32;
  localparam int TX_DEPTH = 32;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_PW = RX_AW + 1;
  localparam int TX_PW = TX_AW + 1;
  localparam int DATA_W = 8;
  localparam int CNT_W = 16;

  // serial frame: flag bit plus eight payload bits
  localparam logic [3:0] FRAME_BITS = 4'd9;
  localparam logic [3:0] LAST_BIT = 4'd8;

  typedef enum logic [2:0] {
    OP_EDGE    = 3'd0,
    OP_SEL_ON  = 3'd1,
    OP_SEL_OFF = 3'd2,
    OP_SEND    = 3'd3,
    OP_RECV    = 3'd4
  } op_t;

  // frame engine requests toward the FIFOs
  typedef struct packed {
    logic              start;   // frame opens, wants a transmit byte
    logic              push;    // valid frame done, payload for receive FIFO
    logic [DATA_W-1:0] rx_byte;
  } frame_req_t;

  function automatic logic [RX_AW-1:0] rx_slot(input logic [RX_PW-1:0] p);
    logic [RX_PW-1:0] d;
    d = (p >= RX_PW'(RX_DEPTH)) ? p - RX_PW'(RX_DEPTH) : p;
    return d[RX_AW-1:0];
  endfunction

  function automatic logic [RX_PW-1:0] rx_next(input logic [RX_PW-1:0] p);
    return (p == RX_PW'(2 * RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_AW-1:0] tx_slot(input logic [TX_PW-1:0] p);
    logic [TX_PW-1:0] d;
    d = (p >= TX_PW'(TX_DEPTH)) ? p - TX_PW'(TX_DEPTH) : p;
    return d[TX_AW-1:0];
  endfunction

  function automatic logic [TX_PW-1:0] tx_next(input logic [TX_PW-1:0] p);
    return (p == TX_PW'(2 * TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// File: rtl/snf_ram.sv
module snf_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/snf_frame.sv
module snf_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [2:0]                    opcode,
  input  logic                          clk_level,
  input  logic                          mosi_level,
  input  logic                          select_level,
  input  logic                          tx_empty,
  input  logic [snf_pkg::DATA_W-1:0]    tx_rd,
  output snf_pkg::frame_req_t           req,
  output logic                          miso
);
  import snf_pkg::*;

  logic [DATA_W-1:0] shift_in, shift_in_next;
  logic [3:0]        bit_count, bit_count_next;
  logic              frame_open, frame_open_next;
  logic              miso_next;
  logic              loaded, loaded_next;   // frame carries a FIFO byte
  logic [2:0]        drive_idx;

  assign drive_idx = 3'(LAST_BIT - bit_count);

  always_comb begin
    shift_in_next   = shift_in;
    bit_count_next  = bit_count;
    frame_open_next = frame_open;
    miso_next       = miso;
    loaded_next     = loaded;
    req             = '0;
    case (opcode)
      OP_EDGE: begin
        if (frame_open && !select_level) begin
          if (!clk_level) begin
            if (bit_count == FRAME_BITS) begin
              req.start = 1'b1;   // burst
            end else if (bit_count != 4'd0) begin
              miso_next = loaded & tx_rd[drive_idx];
            end
          end else if (bit_count < FRAME_BITS) begin
            shift_in_next  = {shift_in[DATA_W-2:0], mosi_level};
            bit_count_next = bit_count + 4'd1;
            req.rx_byte    = {shift_in[DATA_W-2:0], mosi_level};
            // flag bit is active low
            req.push       = (bit_count == LAST_BIT) && !shift_in[DATA_W-1];
          end
        end
      end
      OP_SEL_ON: begin
        frame_open_next = 1'b1;
        req.start       = 1'b1;
      end
      OP_SEL_OFF: begin
        if (frame_open) begin
          frame_open_next = 1'b0;
          bit_count_next  = 4'd0;
          shift_in_next   = '0;
          miso_next       = 1'b1;
          loaded_next     = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (req.start) begin
      bit_count_next = 4'd0;
      shift_in_next  = '0;
      loaded_next    = !tx_empty;
      miso_next      = tx_empty;   // flag bit goes out first
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_in   <= '0;
      bit_count  <= 4'd0;
      frame_open <= 1'b0;
      miso       <= 1'b1;
      loaded     <= 1'b0;
    end else if (en) begin
      shift_in   <= shift_in_next;
      bit_count  <= bit_count_next;
      frame_open <= frame_open_next;
      miso       <= miso_next;
      loaded     <= loaded_next;
    end
  end

endmodule

// File: rtl/spi_slave_nine_bit_fifo_link_unit.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    opcode, clk_level, mosi_level, select_level, send_data
// out      out_valid / out_stall  miso_level, irq_n_level, recv_valid, recv_data,
//                                 send_accepted, rx_overrun_total, tx_drop_total
//
// One transaction per cycle in and out unless out_stall holds a result; each result shows
// in the cycle after its input, as does the registered receive RAM read for recv_data.
// Both FIFOs live in single-port-write, single-port-read synchronous RAMs.
// Synchronous reset clears pointers, counters and the frame engine; RAMs are not cleared.
// in_stall is high only while a result is held by out_stall; a new input is taken
// in the same cycle the waiting result leaves.
module spi_slave_nine_bit_fifo_link_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 opcode,
  input  logic                       clk_level,
  input  logic                       mosi_level,
  input  logic                       select_level,
  input  logic [snf_pkg::DATA_W-1:0] send_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       miso_level,
  output logic                       irq_n_level,
  output logic                       recv_valid,
  output logic [snf_pkg::DATA_W-1:0] recv_data,
  output logic                       send_accepted,
  output logic [snf_pkg::CNT_W-1:0]  rx_overrun_total,
  output logic [snf_pkg::CNT_W-1:0]  tx_drop_total
);
  import snf_pkg::*;

  logic accept;

  logic [RX_PW-1:0] rx_wp, rx_rp;
  logic [TX_PW-1:0] tx_wp, tx_rp;
  logic [CNT_W-1:0] overrun_count, drop_count;

  logic rx_empty, rx_full, tx_empty, tx_full;
  logic rx_we, rx_re, tx_we, tx_re;
  logic send_op, recv_op;

  logic [DATA_W-1:0] rx_rdata, tx_rdata;
  frame_req_t        req;

  // output register frees the input side while it drains
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // full when slots match but pointers differ by one lap
  assign rx_empty = (rx_wp == rx_rp);
  assign rx_full  = !rx_empty && (rx_slot(rx_wp) == rx_slot(rx_rp));
  assign tx_empty = (tx_wp == tx_rp);
  assign tx_full  = !tx_empty && (tx_slot(tx_wp) == tx_slot(tx_rp));

  assign send_op = (opcode == OP_SEND);
  assign recv_op = (opcode == OP_RECV);

  assign tx_we = accept && send_op && !tx_full;
  assign tx_re = accept && req.start && !tx_empty;
  assign rx_we = accept && req.push && !rx_full;
  assign rx_re = accept && recv_op && !rx_empty;

  snf_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .opcode       (opcode),
    .clk_level    (clk_level),
    .mosi_level   (mosi_level),
    .select_level (select_level),
    .tx_empty     (tx_empty),
    .tx_rd        (tx_rdata),
    .req          (req),
    .miso         (miso_level)
  );

  // transmit RAM: read data stays as the shift-out payload of the open frame
  snf_ram #(
    .DEPTH (TX_DEPTH),
    .WIDTH (DATA_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_slot(tx_wp)),
    .wdata (send_data),
    .re    (tx_re),
    .raddr (tx_slot(tx_rp)),
    .rdata (tx_rdata)
  );

  snf_ram #(
    .DEPTH (RX_DEPTH),
    .WIDTH (DATA_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_slot(rx_wp)),
    .wdata (req.rx_byte),
    .re    (rx_re),
    .raddr (rx_slot(rx_rp)),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp         <= '0;
      rx_rp         <= '0;
      tx_wp         <= '0;
      tx_rp         <= '0;
      overrun_count <= '0;
      drop_count    <= '0;
      out_valid     <= 1'b0;
      recv_valid    <= 1'b0;
      send_accepted <= 1'b0;
    end else begin
      if (tx_we) begin
        tx_wp <= tx_next(tx_wp);
      end
      if (tx_re) begin
        tx_rp <= tx_next(tx_rp);
      end
      if (rx_we) begin
        rx_wp <= rx_next(rx_wp);
      end
      if (rx_re) begin
        rx_rp <= rx_next(rx_rp);
      end
      if (accept && req.push && rx_full) begin
        overrun_count <= overrun_count + 1'b1;
      end
      if (accept && send_op && tx_full) begin
        drop_count <= drop_count + 1'b1;
      end
      if (accept) begin
        out_valid     <= 1'b1;
        recv_valid    <= rx_re;
        send_accepted <= tx_we;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // state registers only move on accept, so they read as the post-item result
  assign irq_n_level      = tx_empty;
  assign recv_data        = recv_valid ? rx_rdata : '0;
  assign rx_overrun_total = overrun_count;
  assign tx_drop_total    = drop_count;

  a_rx_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rx_we |-> !rx_full)
    else $error("receive write into unread entry");

  a_tx_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    tx_re |-> !tx_empty)
    else $error("transmit read from empty FIFO");

  a_frame_flag_low: assert property (@(posedge clk) disable iff (rst)
    tx_re |=> !miso_level)
    else $error("popped frame must drive flag low");

  a_recv_only_with_data: assert property (@(posedge clk) disable iff (rst)
    accept && recv_op && rx_empty |=> !recv_valid)
    else $error("receive reported on empty FIFO");

endmodule

// File: tb/sv/spi_slave_nine_bit_fifo_link_unit_checker.sv
module spi_slave_nine_bit_fifo_link_unit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [2:0]                 opcode,
  input  logic                       clk_level,
  input  logic                       mosi_level,
  input  logic                       select_level,
  input  logic [snf_pkg::DATA_W-1:0] send_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       miso_level,
  input  logic                       irq_n_level,
  input  logic                       recv_valid,
  input  logic [snf_pkg::DATA_W-1:0] recv_data,
  input  logic                       send_accepted,
  input  logic [snf_pkg::CNT_W-1:0]  rx_overrun_total,
  input  logic [snf_pkg::CNT_W-1:0]  tx_drop_total,
  output int                         fail_count,
  output int                         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import snf_pkg::*;

  localparam int FRAME_LEN = 9;
  localparam logic [FRAME_LEN-1:0] FILLER_WORD = 9'h100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              miso;
    logic              irq_n;
    logic              rvalid;
    logic [DATA_W-1:0] rdata;
    logic              accepted;
    logic [CNT_W-1:0]  overruns;
    logic [CNT_W-1:0]  drops;
  } line_state_t;

  // mirror of the link state
  logic [DATA_W-1:0]    rx_mem [RX_DEPTH];
  logic [DATA_W-1:0]    tx_mem [TX_DEPTH];
  int                   rx_wr, rx_rd, tx_wr, tx_rd;
  logic [CNT_W-1:0]     overruns, drops;
  logic [FRAME_LEN-1:0] rx_shift, tx_shift;
  int                   bits;
  logic                 frame_live;
  logic                 miso_q;

  line_state_t results_due[$];
  line_state_t want;

  function automatic int ptr_after(int p, int depth);
    return (p + 1 == 2 * depth) ? 0 : p + 1;
  endfunction

  function automatic int fifo_level(int w, int r, int depth);
    return (w - r + 2 * depth) % (2 * depth);
  endfunction

  // frame start: next transmit byte with flag low, or filler when empty
  function automatic void load_frame();
    bits = 0;
    rx_shift = '0;
    if (tx_wr != tx_rd) begin
      tx_shift = {1'b0, tx_mem[tx_rd % TX_DEPTH]};
      tx_rd = ptr_after(tx_rd, TX_DEPTH);
    end else begin
      tx_shift = FILLER_WORD;
    end
    miso_q = tx_shift[FRAME_LEN-1];
  endfunction

  function automatic line_state_t apply_item(logic [2:0] op, logic clk_lv, logic mosi,
                                             logic sel, logic [DATA_W-1:0] data);
    line_state_t r;
    r = '0;
    if (op == OP_EDGE) begin
      if (frame_live && !sel) begin
        if (!clk_lv) begin
          if (bits == FRAME_LEN) load_frame();
          else if (bits != 0) miso_q = tx_shift[FRAME_LEN - 1 - bits];
        end else if (bits < FRAME_LEN) begin
          rx_shift = {rx_shift[FRAME_LEN-2:0], mosi};
          bits++;
          if (bits == FRAME_LEN && !rx_shift[FRAME_LEN-1]) begin
            if (fifo_level(rx_wr, rx_rd, RX_DEPTH) >= RX_DEPTH) begin
              overruns++;
            end else begin
              rx_mem[rx_wr % RX_DEPTH] = rx_shift[DATA_W-1:0];
              rx_wr = ptr_after(rx_wr, RX_DEPTH);
            end
          end
        end
      end
    end else if (op == OP_SEL_ON) begin
      frame_live = 1'b1;
      load_frame();
    end else if (op == OP_SEL_OFF) begin
      if (frame_live) begin
        frame_live = 1'b0;
        bits = 0;
        rx_shift = '0;
        tx_shift = '0;
        miso_q = 1'b1;
      end
    end else if (op == OP_SEND) begin
      if (fifo_level(tx_wr, tx_rd, TX_DEPTH) >= TX_DEPTH) begin
        drops++;
      end else begin
        tx_mem[tx_wr % TX_DEPTH] = data;
        tx_wr = ptr_after(tx_wr, TX_DEPTH);
        r.accepted = 1'b1;
      end
    end else if (op == OP_RECV) begin
      if (rx_rd != rx_wr) begin
        r.rdata = rx_mem[rx_rd % RX_DEPTH];
        r.rvalid = 1'b1;
        rx_rd = ptr_after(rx_rd, RX_DEPTH);
      end
    end
    r.miso = miso_q;
    r.irq_n = (tx_wr == tx_rd);
    r.overruns = overruns;
    r.drops = drops;
    return r;
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want_v, logic [CNT_W-1:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      overruns = '0;
      drops = '0;
      rx_shift = '0;
      tx_shift = '0;
      bits = 0;
      frame_live = 1'b0;
      miso_q = 1'b1;
      results_due.delete();
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(apply_item(opcode, clk_level, mosi_level, select_level,
                                         send_data));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with no transaction pending", $time);
        end else begin
          want = results_due.pop_front();
          check_field("miso_level", CNT_W'(want.miso), CNT_W'(miso_level));
          check_field("irq_n_level", CNT_W'(want.irq_n), CNT_W'(irq_n_level));
          check_field("recv_valid", CNT_W'(want.rvalid), CNT_W'(recv_valid));
          check_field("recv_data", CNT_W'(want.rdata), CNT_W'(recv_data));
          check_field("send_accepted", CNT_W'(want.accepted), CNT_W'(send_accepted));
          check_field("rx_overrun_total", want.overruns, rx_overrun_total);
          check_field("tx_drop_total", want.drops, tx_drop_total);
        end
      end
    end
    pending_results <= results_due.size();
  end

endmodule

// File: tb/sv/spi_slave_nine_bit_fifo_link_unit_tb.sv
module spi_slave_nine_bit_fifo_link_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import snf_pkg::*;

  localparam int TOTAL_ITEMS = 1850;
  localparam int PHASE1_END = 620;
  localparam int PHASE2_END = 1240;
  // receiver hold-off used to back the block up
  localparam int LONG_HOLD = 300;
  // cycles with no transaction on either side before the run is declared hung;
  // several times the long hold-off plus the worst random stall run
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last result, with margin
  localparam int TAIL_CYCLES = 8;
  // enough valid frames in one burst to overrun the receive FIFO
  localparam int FLOOD_FRAMES = RX_DEPTH + 2;
  // opcode with no function; the block only reports its lines
  localparam logic [2:0] OP_SPARE = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        opcode = OP_EDGE;
  logic              clk_level = 1'b0;
  logic              mosi_level = 1'b0;
  logic              select_level = 1'b0;
  logic [DATA_W-1:0] send_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              miso_level;
  logic              irq_n_level;
  logic              recv_valid;
  logic [DATA_W-1:0] recv_data;
  logic              send_accepted;
  logic [CNT_W-1:0]  rx_overrun_total;
  logic [CNT_W-1:0]  tx_drop_total;

  int fail_count;
  int pending_results;
  int items_sent = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  spi_slave_nine_bit_fifo_link_unit u_top (.*);

  spi_slave_nine_bit_fifo_link_unit_checker u_chk (.*);

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [DATA_W-1:0] rbyte();
    return DATA_W'($urandom_range(255));
  endfunction

  // Offer one transaction, with a random lead-in gap, and hold it until taken.
  // Payload only moves when a new transaction starts, so a stalled one stays put.
  task automatic put(logic [2:0] op, logic clk_lv, logic mosi, logic sel,
                     logic [DATA_W-1:0] data);
    while (chance(snd_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    clk_level <= clk_lv;
    mosi_level <= mosi;
    select_level <= sel;
    send_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // one host access: push a byte or pop one
  task automatic host_access();
    if (chance(50)) put(OP_SEND, rbit(), rbit(), rbit(), rbyte());
    else put(OP_RECV, rbit(), rbit(), rbit(), rbyte());
  endtask

  // Clock the top nbits of a word in mode 3: falling edge shifts MISO out,
  // rising edge samples MOSI. With mixing on, stray edges seen with select
  // high and host accesses land between bits.
  task automatic clock_word(logic [8:0] word, int nbits, bit mixed);
    for (int i = 8; i > 8 - nbits; i--) begin
      if (mixed && chance(4)) put(OP_EDGE, rbit(), rbit(), 1'b1, rbyte());
      put(OP_EDGE, 1'b0, rbit(), 1'b0, rbyte());
      if (mixed && chance(5)) host_access();
      put(OP_EDGE, 1'b1, word[i], 1'b0, rbyte());
    end
  endtask

  // Select, one to three back-to-back frames, sometimes a restart or a
  // truncated trailing frame, then release.
  task automatic run_burst();
    int frames;
    frames = $urandom_range(1, 3);
    put(OP_SEL_ON, rbit(), rbit(), rbit(), rbyte());
    repeat (frames) begin
      if (chance(5)) put(OP_SEL_ON, rbit(), rbit(), rbit(), rbyte());
      clock_word({chance(20), rbyte()}, 9, 1'b1);
    end
    if (chance(15)) clock_word({rbit(), rbyte()}, $urandom_range(1, 8), 1'b1);
    // rising edge with a full frame shifted is dropped
    if (chance(30)) put(OP_EDGE, 1'b1, rbit(), 1'b0, rbyte());
    put(OP_SEL_OFF, rbit(), rbit(), rbit(), rbyte());
  endtask

  task automatic random_scenario();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      run_burst();
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 6)) put(OP_SEND, rbit(), rbit(), rbit(), rbyte());
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6)) put(OP_RECV, rbit(), rbit(), rbit(), rbyte());
    end else if (pick < 90) begin
      // stuff the transmit FIFO past full so bytes get dropped
      repeat ($urandom_range(TX_DEPTH + 1, TX_DEPTH + 3))
        put(OP_SEND, rbit(), rbit(), rbit(), rbyte());
    end else begin
      // noise: any opcode, any field values
      put(3'($urandom_range(7)), rbit(), rbit(), rbit(), rbyte());
    end
  endtask

  // sender goes quiet until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_stall <= chance(rcv_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either side resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles lightly, receiver stalls about half the time.
    snd_idle_pct = 14;
    rcv_idle_pct = 53;

    // directed corner cases
    put(OP_RECV, 1'b0, 1'b0, 1'b0, 8'h00);      // pop with receive FIFO empty
    put(OP_EDGE, 1'b1, 1'b1, 1'b0, 8'hFF);      // clock edge with no frame open
    put(OP_SEL_OFF, 1'b1, 1'b1, 1'b1, 8'hFF);   // release with no frame open
    put(OP_SEND, 1'b0, 1'b0, 1'b0, 8'hFF);      // payload extremes into transmit FIFO
    put(OP_SEND, 1'b1, 1'b1, 1'b1, 8'h00);
    put(OP_SPARE, 1'b1, 1'b0, 1'b1, 8'hA5);     // unused opcode leaves state alone
    put(OP_SEL_ON, 1'b0, 1'b0, 1'b0, 8'h00);    // frame opens, takes 0xFF
    put(OP_EDGE, 1'b0, 1'b1, 1'b0, 8'h5A);      // falling edge before any bit shifted
    put(OP_EDGE, 1'b0, 1'b0, 1'b1, 8'h00);      // edge with select high is ignored
    put(OP_SEL_ON, 1'b1, 1'b1, 1'b1, 8'hFF);    // restart inside a frame, takes 0x00
    // valid frame carrying 0xFF, rising edges only
    for (int i = 8; i >= 0; i--) put(OP_EDGE, 1'b1, (i != 8), 1'b0, rbyte());
    put(OP_EDGE, 1'b1, 1'b0, 1'b0, 8'h00);      // extra rising edge after full frame
    put(OP_EDGE, 1'b0, 1'b1, 1'b0, 8'hFF);      // burst: next frame is filler
    put(OP_RECV, 1'b1, 1'b1, 1'b1, 8'h00);      // pop the 0xFF just received
    put(OP_SEL_OFF, 1'b0, 1'b0, 1'b0, 8'h00);   // drop the open frame
    drain();

    while (items_sent < PHASE1_END) random_scenario();
    drain();

    // Phase 2: roles swapped.
    snd_idle_pct = 53;
    rcv_idle_pct = 14;
    while (items_sent < PHASE2_END) random_scenario();
    drain();

    // Phase 3: no idling on either side. The receiver first holds off for a
    // long stretch while the flood below keeps offering, so the block stalls.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_requests++;
    put(OP_SEL_ON, rbit(), rbit(), rbit(), rbyte());
    repeat (FLOOD_FRAMES) clock_word({1'b0, rbyte()}, 9, 1'b0);
    put(OP_SEL_OFF, rbit(), rbit(), rbit(), rbyte());
    repeat (RX_DEPTH + 2) put(OP_RECV, rbit(), rbit(), rbit(), rbyte());
    while (items_sent < TOTAL_ITEMS) random_scenario();
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
